>>> hw/rtl/htll_pkg.sv
// htll_pkg: shared types and codes for the hash tree level layout block.
// No dependencies.
package htll_pkg;

	typedef logic [1:0] err_code_t;

	localparam err_code_t ERR_NONE  = 2'd0;
	localparam err_code_t ERR_ZERO  = 2'd1;
	localparam err_code_t ERR_LEVEL = 2'd2;

	localparam int LEVEL_W = 6;

	typedef logic [LEVEL_W-1:0] level_t;

endpackage

>>> hw/rtl/hash_tree_level_layout.sv
// hash_tree_level_layout: flat layout of a binary hash tree, one level query per item.
// Depends on htll_pkg (error codes, level type).
//
// Each item gives a leaf block count and a level. The block walks the tree from the
// leaves upward, one level per clock: a single shared adder adds the current level's
// node count into the running entry index, while the count is halved (rounded up).
// When the asked level comes by, its start index and node count are captured. The walk
// stops at the single-node root. A finish state then builds the result, reusing the adder
// for the "one past the root" case. in_stall is high during the walk and the finish
// state, so no new item is taken until its result is loaded. The finished result sits in
// an output register, so the next item is accepted while it waits for out_stall to drop;
// a second result can only be loaded once the first is taken, and the finish state
// stalls until then.
// Error 1: zero block count (root level reported as 1, other fields 0).
// Error 2: level more than one above the root (start and count 0).
module hash_tree_level_layout
	import htll_pkg::*;
#(
	parameter int COUNT_BITS = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COUNT_BITS-1:0] block_count,
	input  logic [LEVEL_W-1:0]    tree_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS:0]   level_start_index,
	output logic [COUNT_BITS-1:0] level_node_count,
	output logic [LEVEL_W-1:0]    root_level_out,
	output logic [COUNT_BITS:0]   root_entry_index,
	output logic [1:0]            error_code
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [COUNT_BITS-1:0] n_q;       // node count of current level
	logic [COUNT_BITS:0]   acc_q;     // entry index where current level starts
	level_t                lvl_q;
	level_t                want_q;
	logic                  zero_q;
	logic                  found_q;
	logic [COUNT_BITS:0]   start_q;
	logic [COUNT_BITS-1:0] nodes_q;

	logic [COUNT_BITS:0]   start_out_q;
	logic [COUNT_BITS-1:0] nodes_out_q;
	level_t                root_out_q;
	logic [COUNT_BITS:0]   entry_out_q;
	err_code_t             err_out_q;
	logic                  out_valid_q;

	// shared adder: accumulate during the walk, +1 in the finish cycle
	logic [COUNT_BITS:0]   add_b;
	logic [COUNT_BITS:0]   add_sum;
	logic [COUNT_BITS-1:0] n_half;
	logic                  in_acc;
	logic                  out_take;
	logic                  out_free;
	logic                  one_above;

	assign add_b     = (state_q == ST_RUN) ? {1'b0, n_q} : {{COUNT_BITS{1'b0}}, 1'b1};
	assign add_sum   = acc_q + add_b;
	assign n_half    = (n_q >> 1) + {{(COUNT_BITS-1){1'b0}}, n_q[0]};
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign one_above = ({1'b0, lvl_q} + 7'd1) == {1'b0, want_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (zero_q || n_q == {{(COUNT_BITS-1){1'b0}}, 1'b1}) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q     <= block_count;
			acc_q   <= '0;
			lvl_q   <= '0;
			want_q  <= tree_level;
			zero_q  <= (block_count == '0);
			found_q <= 1'b0;
		end else if (state_q == ST_RUN && !zero_q) begin
			if (lvl_q == want_q) begin
				start_q <= acc_q;
				nodes_q <= n_q;
				found_q <= 1'b1;
			end
			if (n_q != {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
				acc_q <= add_sum;
				n_q   <= n_half;
				lvl_q <= lvl_q + level_t'(1);
			end
		end
		if (state_q == ST_FIN && out_free) begin
			if (zero_q) begin
				start_out_q <= '0;
				nodes_out_q <= '0;
				root_out_q  <= level_t'(1);
				entry_out_q <= '0;
				err_out_q   <= ERR_ZERO;
			end else begin
				root_out_q  <= lvl_q;
				entry_out_q <= acc_q;
				if (found_q) begin
					start_out_q <= start_q;
					nodes_out_q <= nodes_q;
					err_out_q   <= ERR_NONE;
				end else if (one_above) begin
					start_out_q <= add_sum;
					nodes_out_q <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
					err_out_q   <= ERR_NONE;
				end else begin
					start_out_q <= '0;
					nodes_out_q <= '0;
					err_out_q   <= ERR_LEVEL;
				end
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign level_start_index = start_out_q;
	assign level_node_count  = nodes_out_q;
	assign root_level_out    = root_out_q;
	assign root_entry_index  = entry_out_q;
	assign error_code        = err_out_q;

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_FIN) |-> in_stall)
		else $error("input taken during walk");
	a_err_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE || error_code == ERR_ZERO
			|| error_code == ERR_LEVEL))
		else $error("bad error code");
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_ZERO) |->
		(root_level_out == level_t'(1) && level_node_count == '0))
		else $error("zero count result malformed");
	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_NONE) |-> (level_node_count != '0))
		else $error("empty level reported as ok");
`endif

endmodule
